>>> hdl/lj_pair_force_top_defines.svh
// Assertion macros shared by the pair force pipeline modules.
// Expects signals named clock and reset in the including module.
`ifndef LJ_PAIR_FORCE_TOP_DEFINES_SVH
`define LJ_PAIR_FORCE_TOP_DEFINES_SVH

// check chk in the same cycle as cond
`define LJ_ASSERT_COMB(label, cond, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (chk)) \
      else $error(msg);

// check chk in the cycle after cond
`define LJ_ASSERT_NEXT(label, cond, chk, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (chk)) \
      else $error(msg);

`endif

>>> hdl/lj_pkg.sv
// Shared constants, register codes and pipeline record types of the pair force block.
// No dependencies.
`timescale 1ns / 1ps

package lj_pkg;

   localparam int POS_BITS   = 32;
   localparam int SEP_W      = 32;
   localparam int CFG_W      = 31;
   localparam int TYPE_W     = 8;
   localparam int OUT_W      = 48;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int QW         = 64;
   localparam int DIV_LAT    = QW + 1;
   localparam int MUL_LAT    = 2;
   localparam int L1_LEN     = DIV_LAT + 2 * MUL_LAT;
   localparam int L2_LEN     = 2 * MUL_LAT;
   localparam int L3_LEN     = DIV_LAT + MUL_LAT;

   localparam logic [QW-1:0] QMAX = '1;
   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   localparam logic [CFG_W-1:0]  CUTOFF_RST     = 31'd163840;
   localparam logic [CFG_W-1:0]  WELL_DEPTH_RST = 31'd65536;
   localparam logic [CFG_W-1:0]  DIAMETER_RST   = 31'd65536;
   localparam logic [CFG_W-1:0]  ATTRACTION_RST = 31'd65536;
   localparam logic [CFG_W-1:0]  BOX_RST        = 31'd655360;
   localparam logic [TYPE_W-1:0] EXCLUDED_RST   = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CUTOFF,
      CSR_WELL_DEPTH,
      CSR_DIAMETER,
      CSR_ATTRACTION,
      CSR_BOX_X,
      CSR_BOX_Y,
      CSR_BOX_Z,
      CSR_EXCLUDED
   } csr_idx_type;

   typedef struct packed {
      logic                  valid;
      logic                  hit;
      logic [2:0][SEP_W-1:0] sep;
      logic [QW-1:0]         r2;
   } sep_res_type;

   typedef struct packed {
      logic                     valid;
      logic                     hit;
      logic [2:0][SEP_W-1:0]    sep;
      logic [QW-1:0]            r2;
      logic                     fneg;
      logic                     eneg;
      logic                     eneg_sc;
      logic signed [OUT_W-1:0]  energy;
   } pipe_type;

   function automatic logic [SEP_W-1:0] mag32(input logic [SEP_W-1:0] v);
      return v[SEP_W-1] ? SEP_W'(~v + 1'b1) : v;
   endfunction

endpackage

>>> hdl/lj_mulq.sv
// Saturating Q32.32 product (a*b)>>32, two register stages: 32x32 partial products, then the sum.
// Depends on lj_pkg.
`timescale 1ns / 1ps

module lj_mulq (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [lj_pkg::QW-1:0] a,
   input  logic [lj_pkg::QW-1:0] b,
   output logic [lj_pkg::QW-1:0] prod
);
   import lj_pkg::*;

   localparam int HW = QW / 2;
   localparam int SW = QW + HW + 1;

   logic [QW-1:0] ll_ff, lh_ff, hl_ff, hh_ff, prod_ff;
   logic [SW-1:0] sum_in;
   logic [QW-1:0] prod_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff   <= QW'(a[HW-1:0]) * QW'(b[HW-1:0]);
         lh_ff   <= QW'(a[HW-1:0]) * QW'(b[QW-1:HW]);
         hl_ff   <= QW'(a[QW-1:HW]) * QW'(b[HW-1:0]);
         hh_ff   <= QW'(a[QW-1:HW]) * QW'(b[QW-1:HW]);
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      sum_in  = {1'b0, hh_ff, {HW{1'b0}}} + SW'(lh_ff) + SW'(hl_ff) + SW'(ll_ff[QW-1:HW]);
      prod_in = (|sum_in[SW-1:QW]) ? QMAX : sum_in[QW-1:0];
   end

   assign prod = prod_ff;

endmodule

>>> hdl/lj_div.sv
// Saturating Q32.32 quotient floor(num*2^32/den), one quotient bit per register stage.
// Depends on lj_pkg.
`timescale 1ns / 1ps

module lj_div (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [lj_pkg::QW-1:0] num,
   input  logic [lj_pkg::QW-1:0] den,
   output logic [lj_pkg::QW-1:0] quo
);
   import lj_pkg::*;

   localparam int HW = QW / 2;

   logic [QW-1:0] rem_ff [0:QW-1];
   logic [QW-1:0] low_ff [0:QW-1];
   logic [QW-1:0] den_ff [0:QW-1];
   logic [QW-1:0] quo_ff [0:QW];
   logic          ovf_ff [0:QW];
   logic [QW-1:0] rem_in [0:QW-1];
   logic [QW-1:0] low_in [0:QW-1];
   logic [QW-1:0] den_in [0:QW-1];
   logic [QW-1:0] quo_in [0:QW];
   logic          ovf_in [0:QW];
   logic [QW:0]   trial  [1:QW];
   logic          take   [1:QW];

   always_comb begin
      rem_in[0] = QW'(num[QW-1:HW]);
      low_in[0] = {num[HW-1:0], {HW{1'b0}}};
      den_in[0] = den;
      quo_in[0] = '0;
      ovf_in[0] = {{HW{1'b0}}, num} >= {den, {HW{1'b0}}};
      for (int k = 1; k <= QW; k++) begin
         trial[k]  = {rem_ff[k-1], low_ff[k-1][QW-1]};
         take[k]   = trial[k] >= {1'b0, den_ff[k-1]};
         quo_in[k] = {quo_ff[k-1][QW-2:0], take[k]};
         ovf_in[k] = ovf_ff[k-1];
      end
      for (int k = 1; k < QW; k++) begin
         rem_in[k] = take[k] ? QW'(trial[k] - {1'b0, den_ff[k-1]}) : trial[k][QW-1:0];
         low_in[k] = {low_ff[k-1][QW-2:0], 1'b0};
         den_in[k] = den_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            den_ff[k] <= den_in[k];
         end
         for (int k = 0; k <= QW; k++) begin
            quo_ff[k] <= quo_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   assign quo = ovf_ff[QW] ? QMAX : quo_ff[QW];

endmodule

>>> hdl/lj_sep.sv
// Front stages: minimum-image separation per axis, squares, r2 and the cutoff/type test.
// Depends on lj_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "lj_pair_force_top_defines.svh"

module lj_sep (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic signed [lj_pkg::POS_BITS-1:0] first_x,
   input  logic signed [lj_pkg::POS_BITS-1:0] first_y,
   input  logic signed [lj_pkg::POS_BITS-1:0] first_z,
   input  logic signed [lj_pkg::POS_BITS-1:0] second_x,
   input  logic signed [lj_pkg::POS_BITS-1:0] second_y,
   input  logic signed [lj_pkg::POS_BITS-1:0] second_z,
   input  logic [lj_pkg::TYPE_W-1:0]          first_type,
   input  logic [lj_pkg::TYPE_W-1:0]          second_type,
   input  logic [lj_pkg::TYPE_W-1:0]          excluded_type,
   input  logic [lj_pkg::CFG_W-1:0]           box_x,
   input  logic [lj_pkg::CFG_W-1:0]           box_y,
   input  logic [lj_pkg::CFG_W-1:0]           box_z,
   input  logic [lj_pkg::QW-1:0]              cf2,
   output lj_pkg::sep_res_type                res
);
   import lj_pkg::*;

   localparam int DIFF_W = POS_BITS + 1;
   localparam int ADJ_W  = ((DIFF_W > SEP_W + 1) ? DIFF_W : SEP_W + 1) + 1;

   logic signed [POS_BITS-1:0] pa [3];
   logic signed [POS_BITS-1:0] pb [3];
   logic [CFG_W-1:0]           box [3];

   logic                    a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic                    a_excl_ff, b_excl_ff, c_excl_ff, d_excl_ff;
   logic signed [DIFF_W-1:0] a_diff_ff [3];
   logic signed [DIFF_W-1:0] a_diff_in [3];
   logic signed [SEP_W-1:0]  b_sep_ff [3];
   logic signed [SEP_W-1:0]  b_sep_in [3];
   logic signed [SEP_W-1:0]  c_sep_ff [3];
   logic signed [SEP_W-1:0]  d_sep_ff [3];
   logic [QW-1:0]           c_sq_ff [3];
   logic [QW-1:0]           c_sq_in [3];
   logic [QW-1:0]           d_r2_ff;
   logic signed [ADJ_W-1:0] ext [3];
   logic signed [ADJ_W-1:0] dbl [3];
   logic signed [ADJ_W-1:0] len [3];
   logic signed [ADJ_W-1:0] adj [3];

   always_comb begin
      pa[0] = first_x;
      pa[1] = first_y;
      pa[2] = first_z;
      pb[0] = second_x;
      pb[1] = second_y;
      pb[2] = second_z;
      box[0] = box_x;
      box[1] = box_y;
      box[2] = box_z;
      for (int k = 0; k < 3; k++) begin
         a_diff_in[k] = DIFF_W'(pa[k]) - DIFF_W'(pb[k]);
         ext[k] = ADJ_W'(a_diff_ff[k]);
         dbl[k] = ext[k] <<< 1;
         len[k] = ADJ_W'(box[k]);
         priority if (dbl[k] > len[k]) begin
            adj[k] = ext[k] - len[k];
         end else if (dbl[k] < -len[k]) begin
            adj[k] = ext[k] + len[k];
         end else begin
            adj[k] = ext[k];
         end
         if ((&adj[k][ADJ_W-1:SEP_W-1]) || !(|adj[k][ADJ_W-1:SEP_W-1])) begin
            b_sep_in[k] = adj[k][SEP_W-1:0];
         end else begin
            b_sep_in[k] = adj[k][ADJ_W-1] ? {1'b1, {(SEP_W-1){1'b0}}}
                                          : {1'b0, {(SEP_W-1){1'b1}}};
         end
         c_sq_in[k] = QW'(mag32(b_sep_ff[k])) * QW'(mag32(b_sep_ff[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_excl_ff <= (first_type == excluded_type) || (second_type == excluded_type);
         b_excl_ff <= a_excl_ff;
         c_excl_ff <= b_excl_ff;
         d_excl_ff <= c_excl_ff;
         for (int k = 0; k < 3; k++) begin
            a_diff_ff[k] <= a_diff_in[k];
            b_sep_ff[k]  <= b_sep_in[k];
            c_sep_ff[k]  <= b_sep_ff[k];
            c_sq_ff[k]   <= c_sq_in[k];
            d_sep_ff[k]  <= c_sep_ff[k];
         end
         d_r2_ff <= c_sq_ff[0] + c_sq_ff[1] + c_sq_ff[2];
      end
   end

   always_comb begin
      res.valid = d_valid_ff;
      res.hit   = !d_excl_ff && (d_r2_ff < cf2);
      for (int k = 0; k < 3; k++) begin
         res.sep[k] = d_sep_ff[k];
      end
      res.r2 = d_r2_ff;
   end

   `LJ_ASSERT_NEXT(a_load_chk, adv && in_valid, a_valid_ff, "accepted item not in first stage")
   `LJ_ASSERT_NEXT(d_hold_chk, !adv, $stable(d_valid_ff), "stalled stage changed its valid")

endmodule

>>> hdl/lj_pair_force_top.sv
// Lennard-Jones truncated and shifted pair force, one pair per cycle unless stalled. Top level
// with configuration registers and the pipeline. Depends on lj_pkg, lj_sep, lj_div, lj_mulq.
//
// One pair item enters per clock while req_ready is high; results leave in order, one
// result per item. Each item passes the separation stages, the sigma^2/r2 quotient
// pipeline, the cube and product stages, the force magnitude/r2 quotient pipeline and
// the per-axis products; each quotient pipeline gives one bit per stage. The whole
// pipeline holds while a result waits on rsp_ready; req_ready then drops. Write csr_*
// registers only while no item is in flight.
`timescale 1ns / 1ps
`include "lj_pair_force_top_defines.svh"

module lj_pair_force_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [lj_pkg::POS_BITS-1:0]   req_first_x,
   input  logic signed [lj_pkg::POS_BITS-1:0]   req_first_y,
   input  logic signed [lj_pkg::POS_BITS-1:0]   req_first_z,
   input  logic signed [lj_pkg::POS_BITS-1:0]   req_second_x,
   input  logic signed [lj_pkg::POS_BITS-1:0]   req_second_y,
   input  logic signed [lj_pkg::POS_BITS-1:0]   req_second_z,
   input  logic [lj_pkg::TYPE_W-1:0]            req_first_type,
   input  logic [lj_pkg::TYPE_W-1:0]            req_second_type,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [lj_pkg::OUT_W-1:0]      rsp_force_x,
   output logic signed [lj_pkg::OUT_W-1:0]      rsp_force_y,
   output logic signed [lj_pkg::OUT_W-1:0]      rsp_force_z,
   output logic signed [lj_pkg::OUT_W-1:0]      rsp_pair_energy,
   output logic signed [lj_pkg::SEP_W-1:0]      rsp_sep_x,
   output logic signed [lj_pkg::SEP_W-1:0]      rsp_sep_y,
   output logic signed [lj_pkg::SEP_W-1:0]      rsp_sep_z,
   output logic                                 rsp_interacting,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lj_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lj_pkg::CSR_DATA_W-1:0]        csr_data
);
   import lj_pkg::*;

   localparam int ESUM_W = OUT_W + 2;
   localparam logic [QW-1:0] OUT_LIM = QW'(OUT_MAX);

   logic [CFG_W-1:0]  cutoff_ff, well_depth_ff, diameter_ff, attraction_ff;
   logic [CFG_W-1:0]  box_x_ff, box_y_ff, box_z_ff;
   logic [TYPE_W-1:0] excluded_ff;
   logic [QW-1:0]     cf2_ff, sig2_ff;
   logic [QW-1:0]     eps32, aw32, awh;
   logic              adv;

   sep_res_type sres;
   pipe_type    l1_head_in;
   pipe_type    l1_ff [0:L1_LEN-1];
   pipe_type    e_sb_ff, e_sb_in;
   pipe_type    l2_ff [0:L2_LEN-1];
   pipe_type    f_sb_ff, f_sb_in;
   pipe_type    l3_ff [0:L3_LEN-1];

   logic [QW-1:0] rri, sc2, rri2, sc4, rri3, sc6;
   logic [QW-1:0] rri_dly_ff [0:MUL_LAT-1];
   logic [QW-1:0] sc_dly_ff  [0:MUL_LAT-1];
   logic [QW-1:0] e_rri3_ff, e_sc6_ff, e_dm_ff, e_ed_ff, e_eds_ff;
   logic [QW-1:0] e_dm_in, e_ed_in, e_eds_in;
   logic [QW-1:0] p1, p2, e1, e1b, e2, e2b;
   logic [QW+5:0] m_wide;
   logic [QW+1:0] t1_wide, t2_wide;
   logic [QW-1:0] m_in, t1, t2, f_m_ff;
   logic signed [ESUM_W-1:0] sv1, sv2, esum;
   logic [QW-1:0] ft;
   logic [QW-1:0] absep [3];
   logic [QW-1:0] fm [3];

   logic                    rsp_valid_ff, hit_ff;
   logic signed [OUT_W-1:0] force_ff [3];
   logic signed [OUT_W-1:0] force_in [3];
   logic signed [OUT_W-1:0] energy_ff;
   logic signed [SEP_W-1:0] sep_ff [3];
   logic                    big, neg;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff     <= CUTOFF_RST;
         well_depth_ff <= WELL_DEPTH_RST;
         diameter_ff   <= DIAMETER_RST;
         attraction_ff <= ATTRACTION_RST;
         box_x_ff      <= BOX_RST;
         box_y_ff      <= BOX_RST;
         box_z_ff      <= BOX_RST;
         excluded_ff   <= EXCLUDED_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_CUTOFF:     cutoff_ff     <= csr_data[CFG_W-1:0];
            CSR_WELL_DEPTH: well_depth_ff <= csr_data[CFG_W-1:0];
            CSR_DIAMETER:   diameter_ff   <= csr_data[CFG_W-1:0];
            CSR_ATTRACTION: attraction_ff <= csr_data[CFG_W-1:0];
            CSR_BOX_X:      box_x_ff      <= csr_data[CFG_W-1:0];
            CSR_BOX_Y:      box_y_ff      <= csr_data[CFG_W-1:0];
            CSR_BOX_Z:      box_z_ff      <= csr_data[CFG_W-1:0];
            CSR_EXCLUDED:   excluded_ff   <= csr_data[TYPE_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cf2_ff  <= QW'(cutoff_ff) * QW'(cutoff_ff);
      sig2_ff <= QW'(diameter_ff) * QW'(diameter_ff);
   end

   assign eps32 = {{(QW-CFG_W-16){1'b0}}, well_depth_ff, 16'b0};
   assign aw32  = {{(QW-CFG_W-16){1'b0}}, attraction_ff, 16'b0};
   assign awh   = {{(QW-CFG_W-15){1'b0}}, attraction_ff, 15'b0};

   // advance everything unless a result is waiting
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   lj_sep u_sep (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .in_valid      (req_valid),
      .first_x       (req_first_x),
      .first_y       (req_first_y),
      .first_z       (req_first_z),
      .second_x      (req_second_x),
      .second_y      (req_second_y),
      .second_z      (req_second_z),
      .first_type    (req_first_type),
      .second_type   (req_second_type),
      .excluded_type (excluded_ff),
      .box_x         (box_x_ff),
      .box_y         (box_y_ff),
      .box_z         (box_z_ff),
      .cf2           (cf2_ff),
      .res           (sres)
   );

   // sigma^2/r2 and sigma^2/rc^2, then cubes
   lj_div u_div_rri (.clock(clock), .adv(adv), .num(sig2_ff), .den(sres.r2), .quo(rri));
   lj_div u_div_sc  (.clock(clock), .adv(adv), .num(sig2_ff), .den(cf2_ff),  .quo(sc2));

   lj_mulq u_rri2 (.clock(clock), .adv(adv), .a(rri), .b(rri), .prod(rri2));
   lj_mulq u_sc4  (.clock(clock), .adv(adv), .a(sc2), .b(sc2), .prod(sc4));
   lj_mulq u_rri3 (.clock(clock), .adv(adv), .a(rri2), .b(rri_dly_ff[MUL_LAT-1]), .prod(rri3));
   lj_mulq u_sc6  (.clock(clock), .adv(adv), .a(sc4), .b(sc_dly_ff[MUL_LAT-1]), .prod(sc6));

   always_comb begin
      l1_head_in       = '0;
      l1_head_in.valid = sres.valid;
      l1_head_in.hit   = sres.hit;
      l1_head_in.sep   = sres.sep;
      l1_head_in.r2    = sres.r2;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rri_dly_ff[0] <= rri;
         sc_dly_ff[0]  <= sc2;
         for (int k = 1; k < MUL_LAT; k++) begin
            rri_dly_ff[k] <= rri_dly_ff[k-1];
            sc_dly_ff[k]  <= sc_dly_ff[k-1];
         end
      end
   end

   // difference terms
   always_comb begin
      e_sb_in         = l1_ff[L1_LEN-1];
      e_sb_in.fneg    = rri3 < awh;
      e_sb_in.eneg    = rri3 < aw32;
      e_sb_in.eneg_sc = sc6 < aw32;
      e_dm_in  = e_sb_in.fneg ? awh - rri3 : rri3 - awh;
      e_ed_in  = e_sb_in.eneg ? aw32 - rri3 : rri3 - aw32;
      e_eds_in = e_sb_in.eneg_sc ? aw32 - sc6 : sc6 - aw32;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_rri3_ff <= rri3;
         e_sc6_ff  <= sc6;
         e_dm_ff   <= e_dm_in;
         e_ed_ff   <= e_ed_in;
         e_eds_ff  <= e_eds_in;
      end
   end

   lj_mulq u_p1  (.clock(clock), .adv(adv), .a(e_rri3_ff), .b(e_dm_ff),  .prod(p1));
   lj_mulq u_e1  (.clock(clock), .adv(adv), .a(e_rri3_ff), .b(e_ed_ff),  .prod(e1));
   lj_mulq u_e2  (.clock(clock), .adv(adv), .a(e_sc6_ff),  .b(e_eds_ff), .prod(e2));
   lj_mulq u_p2  (.clock(clock), .adv(adv), .a(p1), .b(eps32), .prod(p2));
   lj_mulq u_e1b (.clock(clock), .adv(adv), .a(e1), .b(eps32), .prod(e1b));
   lj_mulq u_e2b (.clock(clock), .adv(adv), .a(e2), .b(eps32), .prod(e2b));

   // scale by 48 and 4, energy difference
   always_comb begin
      m_wide  = ({6'b0, p2} << 5) + ({6'b0, p2} << 4);
      m_in    = (|m_wide[QW+5:QW]) ? QMAX : m_wide[QW-1:0];
      t1_wide = {2'b0, e1b} << 2;
      t2_wide = {2'b0, e2b} << 2;
      t1      = (|t1_wide[QW+1:QW]) ? QMAX : t1_wide[QW-1:0];
      t2      = (|t2_wide[QW+1:QW]) ? QMAX : t2_wide[QW-1:0];
      sv1     = $signed(ESUM_W'(t1[QW-1:16]));
      sv2     = $signed(ESUM_W'(t2[QW-1:16]));
      if (l2_ff[L2_LEN-1].eneg) begin
         sv1 = -sv1;
      end
      if (l2_ff[L2_LEN-1].eneg_sc) begin
         sv2 = -sv2;
      end
      esum    = sv1 - sv2;
      f_sb_in = l2_ff[L2_LEN-1];
      if ((&esum[ESUM_W-1:OUT_W-1]) || !(|esum[ESUM_W-1:OUT_W-1])) begin
         f_sb_in.energy = esum[OUT_W-1:0];
      end else begin
         f_sb_in.energy = esum[ESUM_W-1] ? OUT_MIN : OUT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_m_ff <= m_in;
      end
   end

   // force scalar over r2, then per-axis force
   lj_div u_div_ft (.clock(clock), .adv(adv), .num(f_m_ff), .den(f_sb_ff.r2), .quo(ft));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         absep[k] = QW'(mag32(l3_ff[DIV_LAT-1].sep[k]));
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      lj_mulq u_fm (.clock(clock), .adv(adv), .a(ft), .b(absep[g]), .prod(fm[g]));
   end

   // pipeline records and their valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < L1_LEN; k++) begin
            l1_ff[k].valid <= 1'b0;
         end
         for (int k = 0; k < L2_LEN; k++) begin
            l2_ff[k].valid <= 1'b0;
         end
         for (int k = 0; k < L3_LEN; k++) begin
            l3_ff[k].valid <= 1'b0;
         end
         e_sb_ff.valid <= 1'b0;
         f_sb_ff.valid <= 1'b0;
      end else if (adv) begin
         l1_ff[0] <= l1_head_in;
         for (int k = 1; k < L1_LEN; k++) begin
            l1_ff[k] <= l1_ff[k-1];
         end
         e_sb_ff  <= e_sb_in;
         l2_ff[0] <= e_sb_ff;
         for (int k = 1; k < L2_LEN; k++) begin
            l2_ff[k] <= l2_ff[k-1];
         end
         f_sb_ff  <= f_sb_in;
         l3_ff[0] <= f_sb_ff;
         for (int k = 1; k < L3_LEN; k++) begin
            l3_ff[k] <= l3_ff[k-1];
         end
      end
   end

   // output stage
   always_comb begin
      big = 1'b0;
      neg = 1'b0;
      for (int k = 0; k < 3; k++) begin
         big = fm[k] > OUT_LIM;
         neg = l3_ff[L3_LEN-1].fneg != l3_ff[L3_LEN-1].sep[k][SEP_W-1];
         if (!l3_ff[L3_LEN-1].hit) begin
            force_in[k] = '0;
         end else if (neg) begin
            force_in[k] = big ? OUT_MIN : OUT_W'(~fm[k][OUT_W-1:0] + 1'b1);
         end else begin
            force_in[k] = big ? OUT_MAX : fm[k][OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= l3_ff[L3_LEN-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff    <= l3_ff[L3_LEN-1].hit;
         energy_ff <= l3_ff[L3_LEN-1].hit ? l3_ff[L3_LEN-1].energy : '0;
         for (int k = 0; k < 3; k++) begin
            force_ff[k] <= force_in[k];
            sep_ff[k]   <= l3_ff[L3_LEN-1].hit ? l3_ff[L3_LEN-1].sep[k] : '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_force_x     = force_ff[0];
   assign rsp_force_y     = force_ff[1];
   assign rsp_force_z     = force_ff[2];
   assign rsp_pair_energy = energy_ff;
   assign rsp_sep_x       = sep_ff[0];
   assign rsp_sep_y       = sep_ff[1];
   assign rsp_sep_z       = sep_ff[2];
   assign rsp_interacting = hit_ff;

   `LJ_ASSERT_COMB(zero_out_chk, rsp_valid && !rsp_interacting,
      rsp_force_x == 0 && rsp_force_y == 0 && rsp_force_z == 0 && rsp_pair_energy == 0
      && rsp_sep_x == 0 && rsp_sep_y == 0 && rsp_sep_z == 0,
      "non-interacting item has nonzero fields")
   `LJ_ASSERT_COMB(zero_sep_chk, rsp_valid && rsp_interacting && rsp_sep_x == 0,
      rsp_force_x == 0, "force along an axis with zero separation")
   `LJ_ASSERT_COMB(stall_chk, !req_ready, rsp_valid && !rsp_ready,
      "input held back without an output stall")

endmodule

>>> tb/lj_pair_force_checker.sv
// Checker for the pair force block: tracks register writes, predicts each result and
// compares it field by field. Depends on lj_pkg.
`timescale 1ns / 1ps

module lj_pair_force_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic signed [lj_pkg::POS_BITS-1:0] req_first_x,
   input  logic signed [lj_pkg::POS_BITS-1:0] req_first_y,
   input  logic signed [lj_pkg::POS_BITS-1:0] req_first_z,
   input  logic signed [lj_pkg::POS_BITS-1:0] req_second_x,
   input  logic signed [lj_pkg::POS_BITS-1:0] req_second_y,
   input  logic signed [lj_pkg::POS_BITS-1:0] req_second_z,
   input  logic [lj_pkg::TYPE_W-1:0]          req_first_type,
   input  logic [lj_pkg::TYPE_W-1:0]          req_second_type,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic signed [lj_pkg::OUT_W-1:0]    rsp_force_x,
   input  logic signed [lj_pkg::OUT_W-1:0]    rsp_force_y,
   input  logic signed [lj_pkg::OUT_W-1:0]    rsp_force_z,
   input  logic signed [lj_pkg::OUT_W-1:0]    rsp_pair_energy,
   input  logic signed [lj_pkg::SEP_W-1:0]    rsp_sep_x,
   input  logic signed [lj_pkg::SEP_W-1:0]    rsp_sep_y,
   input  logic signed [lj_pkg::SEP_W-1:0]    rsp_sep_z,
   input  logic                               rsp_interacting,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [lj_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [lj_pkg::CSR_DATA_W-1:0]      csr_data,
   output int                                 pending_count,
   output int                                 fail_count
);
   import lj_pkg::*;

   typedef logic [63:0] q64_type;

   typedef struct {
      logic signed [OUT_W-1:0] force_v [3];
      logic signed [OUT_W-1:0] energy;
      logic signed [SEP_W-1:0] sep [3];
      logic                    interacting;
   } pair_result_type;

   logic [CFG_W-1:0]  cutoff_q, well_depth_q, diameter_q, attraction_q;
   logic [CFG_W-1:0]  box_q [3];
   logic [TYPE_W-1:0] excluded_q;
   pair_result_type   expected_results [$];

   localparam longint OUT_HI = 64'sd140737488355327;
   localparam longint OUT_LO = -64'sd140737488355328;

   function automatic q64_type q_mul(q64_type a, q64_type b);
      logic [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> 32;
      return (p[127:64] != 0) ? '1 : p[63:0];
   endfunction

   function automatic q64_type q_div(q64_type n, q64_type d);
      logic [127:0] q;
      if (d == 0) return '1;
      q = ({64'b0, n} << 32) / {64'b0, d};
      return (q[127:64] != 0) ? '1 : q[63:0];
   endfunction

   function automatic q64_type q_scale(q64_type x, int unsigned k);
      logic [127:0] p;
      p = {64'b0, x} * k;
      return (p[127:64] != 0) ? '1 : p[63:0];
   endfunction

   function automatic longint wrap_sep(logic signed [31:0] a, logic signed [31:0] b,
                                       logic [CFG_W-1:0] box);
      longint d, l;
      d = longint'(a) - longint'(b);
      l = longint'({33'b0, box});
      if (2 * d > l) d = d - l;
      else if (2 * d < -l) d = d + l;
      if (d > 64'sd2147483647) d = 64'sd2147483647;
      if (d < -64'sd2147483648) d = -64'sd2147483648;
      return d;
   endfunction

   function automatic longint shift_term(q64_type x, q64_type w, q64_type eps);
      q64_type m;
      m = q_scale(q_mul(q_mul(x, (x < w) ? w - x : x - w), eps), 4) >> 16;
      return (x < w) ? -longint'(m) : longint'(m);
   endfunction

   function automatic pair_result_type lj_predict(logic signed [31:0] fp [3],
                                                  logic signed [31:0] sp [3],
                                                  logic [7:0] ft, logic [7:0] st);
      pair_result_type res;
      longint s [3];
      q64_type r2, cf2, sig2, eps, aw, awh, rri, rri3, dm, ft_q, sc2, sc6, fm, a;
      logic fneg, neg;
      longint e;
      res.energy = 0;
      res.interacting = 0;
      for (int k = 0; k < 3; k++) begin
         res.force_v[k] = 0;
         res.sep[k] = 0;
      end
      if (ft == excluded_q || st == excluded_q) return res;
      r2 = 0;
      for (int k = 0; k < 3; k++) begin
         s[k] = wrap_sep(fp[k], sp[k], box_q[k]);
         a = (s[k] < 0) ? q64_type'(-s[k]) : q64_type'(s[k]);
         r2 = r2 + a * a;
      end
      cf2 = {33'b0, cutoff_q} * {33'b0, cutoff_q};
      if (!(r2 < cf2)) return res;
      sig2 = {33'b0, diameter_q} * {33'b0, diameter_q};
      eps = {33'b0, well_depth_q} << 16;
      aw = {33'b0, attraction_q} << 16;
      awh = {33'b0, attraction_q} << 15;
      rri = q_div(sig2, r2);
      rri3 = q_mul(q_mul(rri, rri), rri);
      fneg = rri3 < awh;
      dm = fneg ? awh - rri3 : rri3 - awh;
      ft_q = q_div(q_scale(q_mul(q_mul(rri3, dm), eps), 48), r2);
      for (int k = 0; k < 3; k++) begin
         a = (s[k] < 0) ? q64_type'(-s[k]) : q64_type'(s[k]);
         fm = q_mul(ft_q, a);
         neg = fneg != (s[k] < 0);
         if (neg) res.force_v[k] = (fm >= (64'd1 << 47)) ? OUT_MIN : OUT_W'(-longint'(fm));
         else res.force_v[k] = (fm > q64_type'(OUT_HI)) ? OUT_MAX : OUT_W'(fm);
         res.sep[k] = SEP_W'(s[k]);
      end
      sc2 = q_div(sig2, cf2);
      sc6 = q_mul(q_mul(sc2, sc2), sc2);
      e = shift_term(rri3, aw, eps) - shift_term(sc6, aw, eps);
      if (e > OUT_HI) e = OUT_HI;
      if (e < OUT_LO) e = OUT_LO;
      res.energy = OUT_W'(e);
      res.interacting = 1'b1;
      return res;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         fail_count++;
      end
   endtask

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      pair_result_type want;
      logic signed [31:0] fp [3];
      logic signed [31:0] sp [3];
      if (reset) begin
         fail_count = 0;
         cutoff_q <= CUTOFF_RST;
         well_depth_q <= WELL_DEPTH_RST;
         diameter_q <= DIAMETER_RST;
         attraction_q <= ATTRACTION_RST;
         box_q[0] <= BOX_RST;
         box_q[1] <= BOX_RST;
         box_q[2] <= BOX_RST;
         excluded_q <= EXCLUDED_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_CUTOFF:     cutoff_q <= csr_data[CFG_W-1:0];
               CSR_WELL_DEPTH: well_depth_q <= csr_data[CFG_W-1:0];
               CSR_DIAMETER:   diameter_q <= csr_data[CFG_W-1:0];
               CSR_ATTRACTION: attraction_q <= csr_data[CFG_W-1:0];
               CSR_BOX_X:      box_q[0] <= csr_data[CFG_W-1:0];
               CSR_BOX_Y:      box_q[1] <= csr_data[CFG_W-1:0];
               CSR_BOX_Z:      box_q[2] <= csr_data[CFG_W-1:0];
               CSR_EXCLUDED:   excluded_q <= csr_data[TYPE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            fp[0] = req_first_x;
            fp[1] = req_first_y;
            fp[2] = req_first_z;
            sp[0] = req_second_x;
            sp[1] = req_second_y;
            sp[2] = req_second_z;
            expected_results.push_back(lj_predict(fp, sp, req_first_type, req_second_type));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none actual force_x %h",
                        $time, rsp_force_x);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("force_x", want.force_v[0], rsp_force_x);
               check_field("force_y", want.force_v[1], rsp_force_y);
               check_field("force_z", want.force_v[2], rsp_force_z);
               check_field("pair_energy", want.energy, rsp_pair_energy);
               check_field("sep_x", want.sep[0], rsp_sep_x);
               check_field("sep_y", want.sep[1], rsp_sep_y);
               check_field("sep_z", want.sep[2], rsp_sep_z);
               check_field("interacting", want.interacting, rsp_interacting);
            end
         end
      end
   end

endmodule

>>> tb/lj_pair_force_top_tb.sv
// Stimulus and verdict for the pair force block: directed and random pairs over several
// register settings with random idling. Depends on lj_pkg, lj_pair_force_top and the checker.
`timescale 1ns / 1ps

module lj_pair_force_top_tb;
   import lj_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [POS_BITS-1:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic signed [POS_BITS-1:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic [TYPE_W-1:0] req_first_type = '0, req_second_type = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_force_x, rsp_force_y, rsp_force_z, rsp_pair_energy;
   logic signed [SEP_W-1:0] rsp_sep_x, rsp_sep_y, rsp_sep_z;
   logic rsp_interacting;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int pending_count, fail_count;

   logic idle_on = 1'b0;
   int stall_left = 0;
   logic [CFG_W-1:0] cur_cut = CUTOFF_RST;
   logic [CFG_W-1:0] cur_box [3] = '{BOX_RST, BOX_RST, BOX_RST};
   logic [TYPE_W-1:0] cur_excl = EXCLUDED_RST;

   always #5 clock = ~clock;

   lj_pair_force_top uut (.*);
   lj_pair_force_checker checker_i (.*);

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left <= gap_len();
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_pair(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [7:0] ft, logic [7:0] st);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_x <= fx;
      req_first_y <= fy;
      req_first_z <= fz;
      req_second_x <= sx;
      req_second_y <= sy;
      req_second_z <= sz;
      req_first_type <= ft;
      req_second_type <= st;
      forever begin
         @(negedge clock);
         if (req_ready) break;
      end
      @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) break;
      end
      @(posedge clock);
   endtask

   task automatic load_settings(logic [31:0] cut, logic [31:0] eps, logic [31:0] sig,
                                logic [31:0] aw, logic [31:0] bx, logic [31:0] by,
                                logic [31:0] bz, logic [31:0] excl);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      write_reg(CSR_CUTOFF, cut);
      write_reg(CSR_WELL_DEPTH, eps);
      write_reg(CSR_DIAMETER, sig);
      write_reg(CSR_ATTRACTION, aw);
      write_reg(CSR_BOX_X, bx);
      write_reg(CSR_BOX_Y, by);
      write_reg(CSR_BOX_Z, bz);
      write_reg(CSR_EXCLUDED, excl);
      csr_valid <= 1'b0;
      cur_cut = cut[CFG_W-1:0];
      cur_box = '{bx[CFG_W-1:0], by[CFG_W-1:0], bz[CFG_W-1:0]};
      cur_excl = excl[TYPE_W-1:0];
   endtask

   function automatic logic [31:0] near_offset(int axis);
      logic [31:0] off;
      int r;
      r = $urandom_range(0, 99);
      off = (r < 5) ? 32'd0 : $urandom_range(0, cur_cut / 2);
      if (r >= 85) off = off + cur_box[axis];
      return $urandom_range(0, 1) ? -off : off;
   endfunction

   task automatic random_pairs(int count);
      logic [31:0] f [3];
      logic [31:0] s [3];
      logic [7:0] ft, st;
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(0, 99);
         for (int k = 0; k < 3; k++) begin
            f[k] = $urandom();
            s[k] = (kind < 75) ? f[k] - near_offset(k) : $urandom();
         end
         ft = $urandom_range(0, 255);
         st = $urandom_range(0, 255);
         if (kind < 75) begin
            if (ft == cur_excl) ft = ft + 1;
            if (st == cur_excl) st = st + 1;
         end else if (kind < 88) begin
            if ($urandom_range(0, 1)) ft = cur_excl;
            else st = cur_excl;
         end
         send_pair(f[0], f[1], f[2], s[0], s[1], s[2], ft, st);
      end
   endtask

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(0, 0, 0, 0, 0, 0, 1, 2);
      send_pair(65536, 0, 0, 0, 0, 0, 255, 1);
      send_pair(65536, 0, 0, 0, 0, 0, 1, 255);
      send_pair(163840, 0, 0, 0, 0, 0, 1, 1);
      send_pair(163839, 0, 0, 0, 0, 0, 1, 1);
      send_pair(0, 163839, 0, 0, 0, 0, 7, 9);
      send_pair(65536, 0, 0, 0, 0, 0, 0, 0);
      send_pair(0, -98304, 0, 0, 0, 0, 3, 4);
      send_pair(0, 0, 1, 0, 0, 0, 5, 6);
      send_pair(0, 0, 0, 0, 0, 1, 254, 254);
      send_pair(360448, 0, 0, -294912, 0, 0, 1, 2);
      send_pair(294912, 0, 0, -294912, 0, 0, 1, 2);
      send_pair(-294912, 70000, 0, 294912, 0, 0, 1, 2);
      send_pair(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 1, 2);
      send_pair(32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0, 1, 2);
      send_pair('1, '1, '1, '1, '1, '1, 0, 254);
      send_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 128, 127);
      send_pair(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 1, 2);
      send_pair(-1, -1, -1, 0, 0, 0, 85, 170);
      send_pair(40000, -30000, 20000, -10000, 15000, 0, 17, 34);

      idle_on = 1'b1;
      random_pairs(200);
      load_settings(163840, 65536, 65536, 65536, 655360, 655360, 655360, 3);
      idle_on = 1'b0;
      random_pairs(200);
      load_settings(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 1, 1, 0);
      idle_on = 1'b1;
      random_pairs(200);
      load_settings(1, 0, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 255);
      random_pairs(150);
      for (int p = 0; p < 4; p++) begin
         load_settings($urandom_range(32768, 327680), $urandom_range(0, 327680),
                       $urandom_range(32768, 131072), $urandom_range(0, 131072),
                       $urandom_range(131072, 1310720), $urandom_range(131072, 1310720),
                       $urandom_range(131072, 1310720), $urandom_range(0, 255));
         idle_on = p[0];
         random_pairs(150);
      end
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
